>>> hdl/isd_pkg.sv
// Package for the shift-and-subtract integer divider.
// Holds the beat structs, command and state codes, and control structs.
// No dependencies; every other file of the divider imports it.
`timescale 1ns / 1ps
`default_nettype none

package isd_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned HalfW       = 32;
  localparam int unsigned WideSteps   = 64;
  localparam int unsigned NarrowSteps = 32;
  localparam int unsigned CntW        = $clog2(WideSteps);

  typedef enum logic [1:0] {
    CMD_UDIV32 = 2'd0,
    CMD_SDIV32 = 2'd1,
    CMD_UDIV64 = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } in_beat_t;

  typedef struct packed {
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } out_beat_t;

  // Sequencer commands to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_t;

  // Facts about the incoming beat that the sequencer needs at load time.
  typedef struct packed {
    logic skip;
    logic wide;
  } prep_t;

endpackage : isd_pkg

`default_nettype wire

>>> hdl/isd_datapath.sv
// Divider datapath: operand preparation, the shared shift-subtract unit
// and result formatting. Depends on isd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isd_datapath (
  input  wire logic              clk_i,
  input  wire isd_pkg::in_beat_t in_data_i,
  input  wire isd_pkg::ctrl_t    ctrl_i,
  output isd_pkg::prep_t         prep_o,
  output isd_pkg::out_beat_t     out_data_o
);
  import isd_pkg::*;

  logic [DataW-1:0] nq_q, nq_d;
  logic [DataW-1:0] den_q, den_d;
  logic [DataW-1:0] part_q, part_d;
  logic [1:0]       cmd_q;
  logic             neg_q, skip_q;
  out_beat_t        out_q, out_d;

  logic [HalfW-1:0] a32, b32, a_mag, b_mag;
  logic             a_neg, b_neg, is_signed, is_wide;

  logic [DataW-1:0] shifted;
  logic [DataW:0]   diff;
  logic             take;
  logic [HalfW-1:0] q32;

  // Operand preparation for the beat on the input.
  always_comb begin
    a32       = in_data_i.dividend[HalfW-1:0];
    b32       = in_data_i.divisor[HalfW-1:0];
    is_signed = (in_data_i.command == CMD_SDIV32);
    is_wide   = (in_data_i.command == CMD_UDIV64);
    a_neg     = is_signed & a32[HalfW-1];
    b_neg     = is_signed & b32[HalfW-1];
    a_mag     = a_neg ? (~a32 + HalfW'(1)) : a32;
    b_mag     = b_neg ? (~b32 + HalfW'(1)) : b32;
    prep_o.wide = is_wide;
    prep_o.skip = (in_data_i.command == CMD_NONE) ||
                  (is_wide ? (in_data_i.divisor == '0) : (b32 == '0));
  end

  // One restoring step: shift in the next dividend bit, trial subtract.
  // A set top bit before the shift means the shifted value exceeds 64 bits.
  always_comb begin
    shifted = {part_q[DataW-2:0], nq_q[DataW-1]};
    diff    = {1'b0, shifted} - {1'b0, den_q};
    take    = part_q[DataW-1] | ~diff[DataW];
  end

  always_comb begin
    nq_d   = nq_q;
    den_d  = den_q;
    part_d = part_q;
    if (ctrl_i.load) begin
      part_d = '0;
      if (is_wide) begin
        nq_d  = in_data_i.dividend;
        den_d = in_data_i.divisor;
      end else begin
        // The narrow dividend sits in the upper half so that only the
        // narrow number of steps is needed.
        nq_d  = {a_mag, {HalfW{1'b0}}};
        den_d = {{HalfW{1'b0}}, b_mag};
      end
    end else if (ctrl_i.step) begin
      part_d = take ? diff[DataW-1:0] : shifted;
      nq_d   = {nq_q[DataW-2:0], take};
    end
  end

  // Result formatting per command.
  always_comb begin
    q32   = neg_q ? (~nq_q[HalfW-1:0] + HalfW'(1)) : nq_q[HalfW-1:0];
    out_d = '0;
    if (skip_q) begin
      if (cmd_q == CMD_UDIV32) begin
        out_d.remainder = {{HalfW{1'b0}}, nq_q[DataW-1:HalfW]};
      end
    end else begin
      case (cmd_q)
        CMD_UDIV32: begin
          out_d.quotient  = {{HalfW{1'b0}}, nq_q[HalfW-1:0]};
          out_d.remainder = part_q;
        end
        CMD_SDIV32: begin
          out_d.quotient = {{HalfW{1'b0}}, q32};
        end
        CMD_UDIV64: begin
          out_d.quotient  = nq_q;
          out_d.remainder = part_q;
        end
        default: out_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q   <= nq_d;
    den_q  <= den_d;
    part_q <= part_d;
    if (ctrl_i.load) begin
      cmd_q  <= in_data_i.command;
      neg_q  <= a_neg ^ b_neg;
      skip_q <= prep_o.skip;
    end
    if (ctrl_i.finish) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule : isd_datapath

`default_nettype wire

>>> hdl/isd_ctrl.sv
// Divider sequencer: state machine, step counter and output valid flag.
// Depends on isd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire isd_pkg::prep_t prep_i,
  input  wire logic           out_stall_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output isd_pkg::ctrl_t      ctrl_o
);
  import isd_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = prep_i.skip ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        ctrl_o.load = in_valid_i;
      end
      ST_RUN: begin
        ctrl_o.step = 1'b1;
      end
      ST_DONE: begin
        ctrl_o.finish = out_free;
      end
      default: ctrl_o = '0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_o.load) begin
      cnt_d = prep_i.wide ? CntW'(WideSteps - 1) : CntW'(NarrowSteps - 1);
    end else if (ctrl_o.step) begin
      cnt_d = cnt_q - CntW'(1);
    end
    out_valid_d = out_valid_q;
    if (ctrl_o.finish) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule : isd_ctrl

`default_nettype wire

>>> hdl/integer_shift_subtract_divider_top.sv
// Top level of the shift-and-subtract integer divider.
// Each beat passes through the states idle, run and done; a zero divisor or the
// unused command skips the run state. The shared 64-bit subtractor yields one
// quotient bit per cycle while running.
// The divider takes no new beat until the last result is in the output register;
// input stalls while busy and while a finished result waits for the output register.
// Reset is asynchronous, active low, and clears the sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module integer_shift_subtract_divider_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire isd_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output isd_pkg::out_beat_t      out_data_o
);
  import isd_pkg::*;

  ctrl_t ctrl;
  prep_t prep;

  isd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .prep_i      (prep),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  isd_datapath u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .ctrl_i     (ctrl),
    .prep_o     (prep),
    .out_data_o (out_data_o)
  );

endmodule : integer_shift_subtract_divider_top

`default_nettype wire
